/* design/plet_pkg.sv */
`default_nettype none
package plet_pkg;

	localparam int SLOTS     = 64;
	localparam int SLOT_W    = 6;
	localparam int SIZE_W    = 48;
	localparam int HITS_W    = 32;
	localparam int TIME_W    = 64;
	localparam int USED_W    = 54;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_RESERVE = 2'd1,
		MODE_REAP    = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SEARCH,
		ST_DECIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] slot;
		logic              entry_present;
		logic [SIZE_W-1:0] entry_size;
		logic [HITS_W-1:0] entry_hits;
		logic [TIME_W-1:0] entry_access_time;
		logic              entry_invalidated;
		logic              entry_leased;
		logic [SIZE_W-1:0] request_bytes;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] result_slot;
		logic              slot_valid;
		logic              granted;
		logic [USED_W-1:0] held_bytes;
		logic              last;
	} rsp_t;

	// candidate token that ripples along the cell chain
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [HITS_W-1:0] hits;
		logic [TIME_W-1:0] atime;
		logic [SIZE_W-1:0] size;
	} cand_t;

	// control from sequencer to every cell
	typedef struct packed {
		logic              wr;
		logic              reap;   // select on reap criterion rather than LFU/LRU
		logic              kill;   // clear valid of the chosen slot
		logic [SLOT_W-1:0] kill_slot;
	} cell_ctl_t;

endpackage
`default_nettype wire

/* design/plet_cell.sv */
`default_nettype none
// One slot: holds its entry and passes the better of its own entry and the
// incoming candidate on to the next cell, registered.
module plet_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [plet_pkg::SLOT_W-1:0]   my_slot,
	input  wire logic                          wr_sel,
	input  wire plet_pkg::cmd_t                cmd,
	input  wire plet_pkg::cell_ctl_t           ctl,
	input  wire plet_pkg::cand_t               cand_in,
	output plet_pkg::cand_t                    cand_q,
	output logic                               valid_q,
	output logic [plet_pkg::SIZE_W-1:0]        size_q
);
	logic                          inv_q, lease_q;
	logic [plet_pkg::HITS_W-1:0]   hits_q;
	logic [plet_pkg::TIME_W-1:0]   time_q;
	logic                          elig, better;

	// entry storage and valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.wr && wr_sel) begin
			valid_q <= cmd.entry_present;
		end else if (ctl.kill && ctl.kill_slot == my_slot) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && wr_sel) begin
			size_q  <= cmd.entry_size;
			hits_q  <= cmd.entry_hits;
			time_q  <= cmd.entry_access_time;
			inv_q   <= cmd.entry_invalidated;
			lease_q <= cmd.entry_leased;
		end
	end

	// eligibility and comparison; incoming candidate is from a lower slot
	always_comb begin
		if (ctl.reap) begin
			elig   = valid_q && inv_q && !lease_q;
			better = elig && !cand_in.found;
		end else begin
			elig   = valid_q && !inv_q && !lease_q;
			better = elig && (!cand_in.found || hits_q < cand_in.hits ||
				(hits_q == cand_in.hits && time_q < cand_in.atime));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (better) begin
			cand_q <= '{found: 1'b1, slot: my_slot, hits: hits_q,
				atime: time_q, size: size_q};
		end else begin
			cand_q <= cand_in;
		end
	end

endmodule
`default_nettype wire

/* design/plet_seq.sv */
`default_nettype none
// Sequencer: runs writes and searches down the chain and forms the results.
module plet_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire plet_pkg::cmd_t                cmd,
	input  wire logic [plet_pkg::SIZE_W-1:0]   capacity_bytes,
	input  wire plet_pkg::cand_t               chain_out,
	input  wire logic [plet_pkg::USED_W-1:0]   sum_total,
	output logic                               busy,
	output plet_pkg::cmd_t                     cmd_q,
	output plet_pkg::cell_ctl_t                ctl,
	output logic                               strobe,
	output plet_pkg::rsp_t                     result,
	output logic                               closing
);
	localparam int CNT_W = $clog2(plet_pkg::SLOTS + 2);
	localparam logic [CNT_W-1:0] WAIT = CNT_W'(plet_pkg::SLOTS + 1);

	plet_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]             cnt_q;
	logic [plet_pkg::USED_W-1:0]  used_q;
	logic                         any_q;
	logic                         need;

	// used + req > capacity, in 55 bits
	assign need = ({1'b0, used_q} + 55'(cmd_q.request_bytes)) >
		55'(capacity_bytes);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plet_pkg::ST_IDLE:   if (start) state_d = (cmd.mode == plet_pkg::MODE_WRITE) ?
				plet_pkg::ST_WRITE : plet_pkg::ST_SEARCH;
			plet_pkg::ST_WRITE:  state_d = plet_pkg::ST_DONE;
			plet_pkg::ST_SEARCH: if (cnt_q == WAIT) state_d = plet_pkg::ST_DECIDE;
			plet_pkg::ST_DECIDE: state_d = plet_pkg::ST_SEARCH;
			plet_pkg::ST_DONE:   state_d = plet_pkg::ST_IDLE;
			default:             state_d = plet_pkg::ST_IDLE;
		endcase
		if (state_q == plet_pkg::ST_DECIDE) begin
			if (cmd_q.mode == plet_pkg::MODE_NONE) state_d = plet_pkg::ST_IDLE;
			else if (cmd_q.mode == plet_pkg::MODE_RESERVE && !need)
				state_d = plet_pkg::ST_IDLE;
			else if (!chain_out.found) state_d = plet_pkg::ST_IDLE;
		end
	end

	// final decision of a reserve, reap or undefined command
	assign closing = (state_q == plet_pkg::ST_DECIDE) && (state_d == plet_pkg::ST_IDLE);

	// outputs to cells and the result port
	always_comb begin
		ctl       = '0;
		strobe    = 1'b0;
		result    = '0;
		busy      = (state_q != plet_pkg::ST_IDLE);
		ctl.reap  = (cmd_q.mode == plet_pkg::MODE_REAP);
		ctl.wr    = (state_q == plet_pkg::ST_WRITE);
		ctl.kill_slot = chain_out.slot;
		result.held_bytes = used_q;
		if (state_q == plet_pkg::ST_DONE) begin
			strobe = 1'b1;
			result.granted = 1'b1;
			result.held_bytes = sum_total;
			result.last = 1'b1;
		end else if (state_q == plet_pkg::ST_DECIDE) begin
			if (cmd_q.mode == plet_pkg::MODE_NONE) begin
				strobe = 1'b1;
				result.last = 1'b1;
			end else if (cmd_q.mode == plet_pkg::MODE_RESERVE && !need) begin
				strobe = !any_q;
				result.granted = 1'b1;
				result.last = 1'b1;
			end else if (!chain_out.found) begin
				strobe = !any_q;
				result.granted = (cmd_q.mode == plet_pkg::MODE_REAP);
				result.last = 1'b1;
			end else begin
				strobe = 1'b1;
				ctl.kill = 1'b1;
				result.slot_valid = 1'b1;
				result.result_slot = chain_out.slot;
				result.held_bytes = used_q - plet_pkg::USED_W'(chain_out.size);
			end
		end
	end

	// an eviction result is held one decision so that last can be set on it;
	// so removals are delivered late by one decision round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plet_pkg::ST_IDLE;
			cnt_q   <= '0;
			any_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plet_pkg::ST_SEARCH) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (state_q == plet_pkg::ST_IDLE) any_q <= 1'b0;
			else if (ctl.kill) any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == plet_pkg::ST_IDLE && start) cmd_q <= cmd;
		if (state_q == plet_pkg::ST_SEARCH && cnt_q == '0 && !any_q)
			used_q <= sum_total;
		else if (ctl.kill) used_q <= result.held_bytes;
	end

endmodule
`default_nettype wire

/* design/pinned_lfu_lru_eviction_table.sv */
`default_nettype none
// Channel   | Signals                      | Transfer
// command   | start, busy, cmd             | start && !busy
// config    | cfg_valid, cfg_ready, cfg    | cfg_valid && cfg_ready
// result    | strobe, result               | strobe (one cycle, no stall)
// Write: one pass through the write and done states. Reserve/reap/undefined:
// one search round through the cell chain per removal plus one. Reset
// clears valid marks, the resident byte total and the capacity register.
// The receiver cannot stall results.
module pinned_lfu_lru_eviction_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire plet_pkg::cmd_t              cmd,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [plet_pkg::SIZE_W-1:0] cfg,
	output logic                             strobe,
	output plet_pkg::rsp_t                   result
);
	localparam int N = plet_pkg::SLOTS;

	logic [plet_pkg::SIZE_W-1:0] cap_q;
	plet_pkg::cmd_t              cmd_q;
	plet_pkg::cell_ctl_t         ctl;
	plet_pkg::cand_t             chain [N+1];
	logic [N-1:0]                vld;
	logic [plet_pkg::SIZE_W-1:0] sz [N];
	logic [plet_pkg::USED_W-1:0] total_q;
	logic                        closing;
	// last-result buffer: evictions wait one round for their last flag
	plet_pkg::rsp_t              hold_q;
	logic                        hold_v_q;
	logic                        s_strobe;
	plet_pkg::rsp_t              s_res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= '0;
		else if (cfg_valid && cfg_ready) cap_q <= cfg;
	end

	assign chain[0] = '0;
	for (genvar i = 0; i < N; i++) begin : g_cell
		plet_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.my_slot(plet_pkg::SLOT_W'(i)),
			.wr_sel(cmd_q.slot == plet_pkg::SLOT_W'(i)),
			.cmd(cmd_q), .ctl(ctl),
			.cand_in(chain[i]), .cand_q(chain[i+1]),
			.valid_q(vld[i]), .size_q(sz[i]));
	end

	// running total of resident bytes: adjusted on each write and each removal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl.wr) begin
			total_q <= total_q -
				(vld[cmd_q.slot] ? plet_pkg::USED_W'(sz[cmd_q.slot]) : '0) +
				(cmd_q.entry_present ? plet_pkg::USED_W'(cmd_q.entry_size) : '0);
		end else if (ctl.kill) begin
			total_q <= total_q - plet_pkg::USED_W'(chain[N].size);
		end
	end

	plet_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.capacity_bytes(cap_q), .chain_out(chain[N]), .sum_total(total_q),
		.busy(busy), .cmd_q(cmd_q), .ctl(ctl),
		.strobe(s_strobe), .result(s_res), .closing(closing));

	// removal results are parked; a later removal releases the parked one, and the closing decision releases it with last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_v_q <= 1'b0;
		else if (s_strobe && !s_res.last) hold_v_q <= 1'b1;
		else if (closing) hold_v_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (s_strobe && !s_res.last) hold_q <= s_res;
	end

	always_comb begin
		strobe = 1'b0;
		result = s_res;
		if (s_strobe && !s_res.last) begin
			strobe = hold_v_q;
			result = hold_q;
		end else if (s_strobe) begin
			strobe = 1'b1;
		end else if (hold_v_q && closing) begin
			strobe = 1'b1;
			result = hold_q;
			result.last = 1'b1;
			result.granted = (cmd_q.mode == plet_pkg::MODE_REAP) ||
				(({1'b0, hold_q.held_bytes} + 55'(cmd_q.request_bytes)) <=
				55'(cap_q));
		end
	end

	a_busy_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside operation");
	a_slot_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.slot_valid) |-> result.last)
		else $error("non-removal result not last");
	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("command not taken");

endmodule
`default_nettype wire
